// ===== hw/rtl/unique_device_tally_with_rssi_stats_defines.svh =====
// Assertion macros for the unique device tally block.
// Used by the checker; no other dependencies.
`ifndef UNIQUE_DEVICE_TALLY_WITH_RSSI_STATS_DEFINES_SVH
`define UNIQUE_DEVICE_TALLY_WITH_RSSI_STATS_DEFINES_SVH

// same-cycle implication
`define UDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/udt_pkg.sv =====
// Shared types and constants for the unique device tally block.
// No dependencies.
package udt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W            = 48;
    localparam int KIND_W            = 8;
    localparam int KEY_W             = ADDR_W + KIND_W;
    localparam int RSSI_W            = 8;
    localparam int CNT_W             = 16;
    localparam int SUM_W             = 24;

    localparam logic signed [RSSI_W-1:0] THRESH_RESET = -8'sd70;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [ADDR_W-1:0]        device_address;
        logic [KIND_W-1:0]        address_kind;
        logic signed [RSSI_W-1:0] signal_strength;
    } in_item_t;

    typedef struct packed {
        logic                     was_new;
        logic [CNT_W-1:0]         total_devices;
        logic [CNT_W-1:0]         close_devices;
        logic signed [RSSI_W-1:0] average_strength;
    } out_item_t;

    // search token passed along the cell chain
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [KEY_W-1:0] key;
    } token_t;

endpackage

// ===== hw/rtl/udt_cell.sv =====
// One table entry of the search chain: compares, stores, forwards the token.
// Depends on udt_pkg.
module udt_cell #(
    parameter int IDX  = 0,
    parameter int FILL_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FILL_W-1:0]   fill,
    input  udt_pkg::token_t     tok_in,
    output udt_pkg::token_t     tok_out
);

    logic [udt_pkg::KEY_W-1:0] entry_reg;
    logic                      vld_reg;
    logic                      hit_reg;
    logic [udt_pkg::KEY_W-1:0] key_reg;
    logic                      in_use;
    logic                      match;
    logic                      store;

    assign in_use = FILL_W'(IDX) < fill;
    assign match  = in_use && (entry_reg == tok_in.key);
    // first free slot takes the key if no earlier entry matched
    assign store  = tok_in.vld && !tok_in.hit && (FILL_W'(IDX) == fill);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= tok_in.hit | match;
        key_reg <= tok_in.key;
        if (store)
        begin
            entry_reg <= tok_in.key;
        end
    end

    assign tok_out.vld = vld_reg;
    assign tok_out.hit = hit_reg;
    assign tok_out.key = key_reg;

endmodule

// ===== hw/rtl/udt_divider.sv =====
// Bit-serial signed-by-unsigned divider with 8-bit saturated quotient.
// Depends on udt_pkg.
module udt_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [udt_pkg::SUM_W-1:0]    dividend,
    input  logic [udt_pkg::CNT_W-1:0]           divisor,
    output logic                                done,
    output logic signed [udt_pkg::RSSI_W-1:0]   quotient
);

    localparam int SW     = udt_pkg::SUM_W;
    localparam int DW     = udt_pkg::CNT_W;
    localparam int STEP_W = $clog2(SW);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [SW-1:0]     mag_reg, mag_next;
    logic [DW:0]       rem_reg, rem_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [DW:0]       rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[DW-1:0], mag_reg[SW-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            neg_next  = dividend[SW-1];
            mag_next  = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            mag_next  = {mag_reg[SW-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (mag_reg > SW'(128)) ? -8'sd128 : (~mag_reg[7:0] + 8'd1);
        end
        else
        begin
            quotient = (mag_reg > SW'(127)) ? 8'sd127 : mag_reg[7:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/unique_device_tally_with_rssi_stats.sv =====
// Unique device tally with RSSI statistics: top level.
// Depends on udt_pkg, udt_cell, udt_divider.
//
// Usage:
//   req channel (req_valid / req_stall / req) takes one report or clear item.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one result per item.
//   cfg_write / cfg_data load the signed close threshold (reset -70).
// Flow: a report's key walks the chain of TABLE_ENTRIES cells, one cell
//   per cycle; for a new device a 24-step serial divide then forms the
//   average (skipped if the count wraps to zero). A duplicate's result loads
//   once its key leaves the chain, and a clear's goes straight to the done state.
// Occupancy: one item at a time; req_stall is high from acceptance until the
//   result is loaded into the output register. The next item may be accepted
//   while that result still waits on rsp_stall.
// Reset: counts, sum, fill count and average clear, threshold goes to -70,
//   no result is pending. Table entries need no clear; only filled ones match.
// Stall: a pending result holds in the output register; a finished item
//   waits in its final state until the register frees.
module unique_device_tally_with_rssi_stats #(
    parameter int TABLE_ENTRIES = udt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  udt_pkg::in_item_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output udt_pkg::out_item_t                  rsp,
    input  logic                                cfg_write,
    input  logic signed [udt_pkg::RSSI_W-1:0]   cfg_data
);

    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CW     = udt_pkg::CNT_W;
    localparam int SW     = udt_pkg::SUM_W;
    localparam int RW     = udt_pkg::RSSI_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [CW-1:0]            total_reg, total_next;
    logic [CW-1:0]            close_reg, close_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic signed [RW-1:0]     avg_reg, avg_next;
    logic                     new_reg, new_next;
    logic signed [RW-1:0]     thr_reg;
    logic signed [RW-1:0]     rssi_reg, rssi_next;
    udt_pkg::token_t          head_reg, head_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    udt_pkg::out_item_t       rsp_reg, rsp_next;
    logic                     div_start;
    logic                     div_done;
    logic signed [RW-1:0]     div_q;
    logic                     accept;

    udt_pkg::token_t          chain [0:TABLE_ENTRIES];

    assign chain[0] = head_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        udt_cell #(
            .IDX    (i),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .fill    (fill_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    udt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (total_next),
        .done     (div_done),
        .quotient (div_q)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        close_next     = close_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        new_next       = new_reg;
        rssi_next      = rssi_reg;
        head_next      = head_reg;
        head_next.vld  = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == udt_pkg::CMD_CLEAR)
                    begin
                        fill_next  = '0;
                        total_next = '0;
                        close_next = '0;
                        sum_next   = '0;
                        avg_next   = '0;
                        new_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        head_next.vld = 1'b1;
                        head_next.hit = 1'b0;
                        head_next.key = {req.device_address, req.address_kind};
                        rssi_next     = req.signal_strength;
                        state_next    = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (chain[TABLE_ENTRIES].vld)
                begin
                    new_next = !chain[TABLE_ENTRIES].hit;
                    if (chain[TABLE_ENTRIES].hit)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (fill_reg < FILL_W'(TABLE_ENTRIES))
                        begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                        total_next = total_reg + CW'(1);
                        sum_next   = sum_reg + SW'(rssi_reg);
                        if (rssi_reg > thr_reg)
                        begin
                            close_next = close_reg + CW'(1);
                        end
                        if (total_next == '0)
                        begin
                            avg_next   = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIVIDE;
                        end
                    end
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    avg_next   = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.was_new          = new_reg;
                    rsp_next.total_devices    = total_reg;
                    rsp_next.close_devices    = close_reg;
                    rsp_next.average_strength = avg_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            close_reg     <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            new_reg       <= 1'b0;
            thr_reg       <= udt_pkg::THRESH_RESET;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            close_reg     <= close_next;
            sum_reg       <= sum_next;
            avg_reg       <= avg_next;
            new_reg       <= new_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rssi_reg <= rssi_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/udt_checker.sv =====
// Port-level checker for the unique device tally block, bound to the top level.
// Depends on udt_pkg and the assertion macro header.
`include "unique_device_tally_with_rssi_stats_defines.svh"

module udt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  udt_pkg::out_item_t                  rsp
);

    `UDT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp), "stalled rsp item changed")
    `UDT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall,
        req_stall, "no stall after an accepted item")
    `UDT_ASSERT_IMP(a_zero_avg, clk, rst_n, rsp_valid && (rsp.total_devices == '0),
        rsp.average_strength == '0, "nonzero average with zero count")
    `UDT_ASSERT_IMP(a_rsp_from_busy, clk, rst_n, $rose(rsp_valid),
        $past(req_stall), "result appeared with no item in work")

endmodule

bind unique_device_tally_with_rssi_stats udt_checker u_udt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== tb/sv/unique_device_tally_with_rssi_stats_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for unique_device_tally_with_rssi_stats: scoreboard class
// with a device-tally predictor, stimulus/stall tasks and a watchdog.
// Depends on udt_pkg and the RTL top level only.
import udt_pkg::*;

class tally_scoreboard;
    logic [KEY_W-1:0]         seen_keys[$];
    logic [CNT_W-1:0]         total_cnt;
    logic [CNT_W-1:0]         close_cnt;
    logic [SUM_W-1:0]         strength_acc;
    logic signed [RSSI_W-1:0] threshold;
    out_item_t                expected_q[$];
    int errors;
    int items_in;
    int results_in;
    int clears_in;
    int full_hits;

    function new();
        threshold = THRESH_RESET;
        wipe();
    endfunction

    function void wipe();
        seen_keys.delete();
        total_cnt    = '0;
        close_cnt    = '0;
        strength_acc = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function logic signed [RSSI_W-1:0] average_now();
        int s;
        int t;
        int q;
        if (total_cnt == 0)
            return '0;
        s = $signed(strength_acc);
        t = total_cnt;
        q = s / t;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[RSSI_W-1:0];
    endfunction

    function void note_input(in_item_t it);
        out_item_t        r;
        logic [KEY_W-1:0] key;
        bit               hit;
        items_in++;
        r = '0;
        if (it.command == CMD_CLEAR)
        begin
            clears_in++;
            wipe();
        end
        else
        begin
            key = {it.device_address, it.address_kind};
            hit = 0;
            foreach (seen_keys[i])
                if (seen_keys[i] == key)
                    hit = 1;
            if (!hit)
            begin
                if (seen_keys.size() < TABLE_ENTRIES_DEF)
                    seen_keys.push_back(key);
                else
                    full_hits++;
                total_cnt    = total_cnt + 1'b1;
                strength_acc = strength_acc
                               + {{(SUM_W-RSSI_W){it.signal_strength[RSSI_W-1]}},
                                  it.signal_strength};
                if ($signed(it.signal_strength) > threshold)
                    close_cnt = close_cnt + 1'b1;
                r.was_new = 1'b1;
            end
        end
        r.total_devices    = total_cnt;
        r.close_devices    = close_cnt;
        r.average_strength = average_now();
        expected_q.push_back(r);
    endfunction

    task check_result(out_item_t got);
        out_item_t e;
        results_in++;
        if (expected_q.size() == 0)
        begin
            report("result with no item outstanding");
            return;
        end
        e = expected_q.pop_front();
        if (got.was_new !== e.was_new)
            report($sformatf("result %0d was_new %b, want %b", results_in,
                             got.was_new, e.was_new));
        if (got.total_devices !== e.total_devices)
            report($sformatf("result %0d total_devices %0d, want %0d", results_in,
                             got.total_devices, e.total_devices));
        if (got.close_devices !== e.close_devices)
            report($sformatf("result %0d close_devices %0d, want %0d", results_in,
                             got.close_devices, e.close_devices));
        if (got.average_strength !== e.average_strength)
            report($sformatf("result %0d average_strength %0d, want %0d", results_in,
                             $signed(got.average_strength), $signed(e.average_strength)));
    endtask
endclass

module unique_device_tally_with_rssi_stats_tb;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 128;
    localparam int HOLD_CYCLES = 400;
    localparam int WDOG_LIMIT  = 4000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    in_item_t                 req;
    logic                     rsp_valid;
    logic                     rsp_stall;
    out_item_t                rsp;
    logic                     cfg_write;
    logic signed [RSSI_W-1:0] cfg_data;

    tally_scoreboard sb = new();
    logic [KEY_W-1:0] key_pool[$];
    bit calm;
    bit held;
    int thresholds_written;
    int idle_cycles;

    unique_device_tally_with_rssi_stats DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [63:0] r64;
        r64 = {$urandom(), $urandom()};
        return r64[KEY_W-1:0];
    endfunction

    task automatic send_item(in_item_t it);
        int n;
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_input(it);
        n = calm ? 0 : gap_len();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_report(logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind,
                               logic signed [RSSI_W-1:0] rssi);
        in_item_t it;
        it.command         = CMD_REPORT;
        it.device_address  = addr;
        it.address_kind    = kind;
        it.signal_strength = rssi;
        send_item(it);
    endtask

    task automatic send_clear(logic [KEY_W+RSSI_W-1:0] junk);
        in_item_t it;
        it = {CMD_CLEAR, junk};
        send_item(it);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(logic signed [RSSI_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.threshold = v;
        thresholds_written++;
    endtask

    function automatic in_item_t make_item();
        in_item_t         it;
        logic [KEY_W-1:0] key;
        int               r;
        r = $urandom_range(0, 149);
        key = random_key();
        if (r >= 1 && r <= 104)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r >= 95 && r <= 104)
            key[KIND_W-1:0] = KIND_W'($urandom_range(0, 255));
        it.command         = (r == 0) ? CMD_CLEAR : CMD_REPORT;
        it.device_address  = key[KEY_W-1:KIND_W];
        it.address_kind    = key[KIND_W-1:0];
        it.signal_strength = RSSI_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            it.signal_strength = sb.threshold + RSSI_W'($urandom_range(0, 1));
        return it;
    endfunction

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        int n;
        rsp_stall <= 1'b0;
        held = 0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!held && sb.items_in >= 300)
            begin
                held = 1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                n = gap_len();
                if (!calm && n > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic signed [RSSI_W-1:0] thr;
        int pool_size;
        rst_n       = 1'b0;
        calm        = 0;
        thresholds_written = 0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_write <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, threshold first at its reset value, then at both extremes
        send_report('0, 8'h00, -8'sd128);
        send_report('0, 8'h00, 8'sd5);
        send_report('0, 8'h01, 8'sd127);
        send_report({ADDR_W{1'b1}}, 8'hff, -8'sd70);
        send_report({ADDR_W{1'b1}}, 8'hff, 8'sd127);
        send_report({24{2'b10}}, 8'h55, -8'sd69);
        send_report({24{2'b01}}, 8'haa, 8'sd0);
        send_clear({(KEY_W+RSSI_W){1'b1}});
        send_report('0, 8'h00, -8'sd1);
        send_clear('0);
        send_clear('0);
        wait_drained();
        write_threshold(-8'sd128);
        send_report(48'h1, 8'h02, -8'sd128);
        send_report(48'h2, 8'h02, -8'sd127);
        wait_drained();
        write_threshold(8'sd127);
        send_report(48'h3, 8'h02, 8'sd127);
        send_report(48'h3, 8'h02, -8'sd128);

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       thr = -8'sd128;
                1:       thr = 8'sd127;
                2:       thr = THRESH_RESET;
                default: thr = RSSI_W'($urandom_range(0, 255));
            endcase
            write_threshold(thr);
            calm = (p % 4 == 2);
            pool_size = (p % 3 == 0) ? 6 : (p % 3 == 1) ? 40 : 100;
            key_pool.delete();
            repeat (pool_size) key_pool.push_back(random_key());
            if (p % 3 == 0)
                send_clear({random_key(), RSSI_W'($urandom())});
            repeat (PHASE_ITEMS) send_item(make_item());
        end

        wait_drained();
        repeat (120) @(posedge clk);
        $display("covered %0d items (%0d clears, %0d counted with the table full), %0d results",
                 sb.items_in, sb.clears_in, sb.full_hits, sb.results_in);
        $display("threshold written %0d times including both extremes", thresholds_written);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== unique_device_tally_with_rssi_stats.f =====
+incdir+hw/rtl
hw/rtl/udt_pkg.sv
hw/rtl/udt_cell.sv
hw/rtl/udt_divider.sv
hw/rtl/unique_device_tally_with_rssi_stats.sv
hw/rtl/udt_checker.sv
tb/sv/unique_device_tally_with_rssi_stats_tb.sv
